// ----- rtl/core/order_book_price_level_table_core_assert.svh -----
// Assertion macros for the price level table core.
// Used by the core top level; expects clk and rst_n in scope.
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_CORE_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define OBPLT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obplt assertion failed");

// next-cycle implication
`define OBPLT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obplt assertion failed");

`endif

// ----- rtl/core/obplt_pkg.sv -----
// Package for the price level table core: operation, status and register codes,
// and the configuration register struct. No dependencies.
`timescale 1ns / 1ps
package obplt_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_BEST   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BELOW     = 3'd4;

    localparam logic [1:0] REG_SIDE  = 2'd0;
    localparam logic [1:0] REG_TICK  = 2'd1;
    localparam logic [1:0] REG_LOWER = 2'd2;
    localparam logic [1:0] REG_UPPER = 2'd3;

    typedef struct packed {
        logic        side;
        logic [15:0] tick;
        logic [31:0] lower_bound;
        logic [31:0] upper_bound;
    } cfg_t;

endpackage

// ----- rtl/core/order_book_price_level_table_core.sv -----
// Price level table core: sequencer, level and slot memories, result register.
// Depends on obplt_pkg, obplt_cfg, obplt_div and the assertion macro header.
//
// Usage: one side of an order book. Items enter on in_valid/in_ready with
// operation, order_id and price; each item gives exactly one result on
// out_valid/out_ready. Registers are to be written over the APB-style port
// only while idle; the core itself does not enforce this.
// Steps per item: insert/remove/lookup run the divider for level count,
// quotient and modulo, scan the level's slots and, on remove, move the later
// slots down. best runs the divider for the level count and scans the levels.
// clear clears one level count per cycle. A price below bound or an unused
// code goes straight to the result. The shared serial divider and the single
// read port of each memory set the pace of these steps.
// One item is in work at a time; in_ready is low until its result is registered.
// After reset the level counts are cleared in a pass over all levels during
// which no item is accepted. A stalled receiver holds the result register; the
// next item may be accepted meanwhile, but its result waits until the register
// is freed.
`timescale 1ns / 1ps
`include "order_book_price_level_table_core_assert.svh"
module order_book_price_level_table_core
#(
    parameter int LEVELS = 256,
    parameter int SLOTS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] order_id,
    input  logic [31:0] price,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        found,
    output logic [12:0] total_orders,
    output logic        best_valid,
    output logic [31:0] best_price,
    output logic [31:0] best_order_id
);

    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW    = $clog2(LEVELS + 1);
    localparam int FW    = $clog2(SLOTS + 1);
    localparam int DEPTH = LEVELS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CNT  = 4'd2;
    localparam logic [3:0] S_QDIV = 4'd3;
    localparam logic [3:0] S_MOD  = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FWT  = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCMP = 4'd8;
    localparam logic [3:0] S_DEC  = 4'd9;
    localparam logic [3:0] S_MRD  = 4'd10;
    localparam logic [3:0] S_MWR  = 4'd11;
    localparam logic [3:0] S_BEST = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    obplt_pkg::cfg_t cfg;

    logic [3:0]    state_reg;
    logic          go_reg;
    logic          clr_resp_reg;
    logic [LW-1:0] clr_idx_reg;
    logic [2:0]    op_reg;
    logic [31:0]   id_reg;
    logic [31:0]   price_reg;
    logic [CW-1:0] count_reg;
    logic [LW-1:0] lvl_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] slot_i_reg;
    logic          hit_reg;
    logic [CW-1:0] best_idx_reg;
    logic          pend_reg;
    logic [TW-1:0] total_reg;

    logic [2:0]    res_status_reg;
    logic          res_found_reg;
    logic          res_bv_reg;
    logic [31:0]   res_bp_reg;
    logic [31:0]   res_bid_reg;

    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic          out_found_reg;
    logic [12:0]   out_total_reg;
    logic          out_bv_reg;
    logic [31:0]   out_bp_reg;
    logic [31:0]   out_bid_reg;

    logic [FW-1:0] fill_mem [LEVELS];
    logic [31:0]   id_mem [DEPTH];
    logic [31:0]   price_mem [DEPTH];
    logic [FW-1:0] fill_q;
    logic [31:0]   id_q;
    logic [31:0]   price_q;

    logic          fill_we;
    logic [LW-1:0] fill_waddr;
    logic [FW-1:0] fill_wdata;
    logic [LW-1:0] fill_raddr;
    logic          slot_we;
    logic [AW-1:0] slot_waddr;
    logic [31:0]   slot_wid;
    logic [31:0]   slot_wprice;
    logic [AW-1:0] slot_raddr;

    logic          div_done;
    logic [31:0]   div_quot;
    logic [31:0]   div_rem;
    logic [31:0]   div_dividend;
    logic [31:0]   div_divisor;
    logic [31:0]   tick_eff;

    logic          accept;
    logic          fill_has_room;
    logic          more_to_move;
    logic          best_better;

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l,
                                                input logic [FW:0] i);
        slot_addr = AW'(AW'(l) * AW'(SLOTS)) + AW'(i);
    endfunction

    obplt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign tick_eff = (cfg.tick == 16'd0) ? 32'd1 : {16'd0, cfg.tick};

    always_comb
    begin
        case (state_reg)
            S_CNT:
            begin
                div_dividend = (cfg.upper_bound < cfg.lower_bound) ? 32'd0 :
                               32'(cfg.upper_bound - cfg.lower_bound);
                div_divisor  = tick_eff;
            end
            S_QDIV:
            begin
                div_dividend = 32'(price_reg - cfg.lower_bound);
                div_divisor  = tick_eff;
            end
            default:
            begin
                div_dividend = div_quot;
                div_divisor  = 32'(count_reg);
            end
        endcase
    end

    obplt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (go_reg),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign accept        = in_valid && in_ready;
    assign in_ready      = (state_reg == S_IDLE);
    assign fill_has_room = ({1'b0, fill_reg} < (FW + 1)'(SLOTS));
    assign more_to_move  = (({1'b0, slot_i_reg} + (FW + 1)'(1)) < {1'b0, fill_reg});
    assign best_better   = !res_bv_reg ||
                           (cfg.side ? (price_q < res_bp_reg) : (price_q > res_bp_reg));

    always_comb
    begin
        fill_raddr = (state_reg == S_BEST) ? best_idx_reg[LW-1:0] : lvl_reg;
        case (state_reg)
            S_BEST:  slot_raddr = slot_addr(best_idx_reg[LW-1:0], '0);
            S_MRD:   slot_raddr = slot_addr(lvl_reg, {1'b0, slot_i_reg} + (FW + 1)'(1));
            default: slot_raddr = slot_addr(lvl_reg, {1'b0, slot_i_reg});
        endcase
    end

    always_comb
    begin
        fill_we     = 1'b0;
        fill_waddr  = lvl_reg;
        fill_wdata  = fill_reg;
        slot_we     = 1'b0;
        slot_waddr  = slot_addr(lvl_reg, {1'b0, slot_i_reg});
        slot_wid    = id_q;
        slot_wprice = price_q;
        case (state_reg)
            S_CLR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_idx_reg;
                fill_wdata = '0;
            end
            S_DEC:
            begin
                if (op_reg == obplt_pkg::OP_INSERT && !hit_reg && fill_has_room)
                begin
                    fill_we     = 1'b1;
                    fill_wdata  = FW'(fill_reg + FW'(1));
                    slot_we     = 1'b1;
                    slot_waddr  = slot_addr(lvl_reg, {1'b0, fill_reg});
                    slot_wid    = id_reg;
                    slot_wprice = price_reg;
                end
            end
            S_MRD:
            begin
                if (!more_to_move)
                begin
                    fill_we    = 1'b1;
                    fill_wdata = FW'(fill_reg - FW'(1));
                end
            end
            S_MWR:
            begin
                slot_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_q <= fill_mem[fill_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            id_mem[slot_waddr]    <= slot_wid;
            price_mem[slot_waddr] <= slot_wprice;
        end
        id_q    <= id_mem[slot_raddr];
        price_q <= price_mem[slot_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            go_reg        <= 1'b0;
            clr_resp_reg  <= 1'b0;
            clr_idx_reg   <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= LW'(clr_idx_reg + LW'(1));
                    if (clr_idx_reg == LW'(LEVELS - 1))
                    begin
                        clr_idx_reg <= '0;
                        state_reg   <= clr_resp_reg ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        clr_resp_reg <= 1'b0;
                        if (operation inside {obplt_pkg::OP_INSERT, obplt_pkg::OP_REMOVE,
                                              obplt_pkg::OP_LOOKUP}
                            && price < cfg.lower_bound)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (operation == obplt_pkg::OP_CLEAR)
                        begin
                            total_reg    <= '0;
                            clr_resp_reg <= 1'b1;
                            clr_idx_reg  <= '0;
                            state_reg    <= S_CLR;
                        end
                        else if (operation inside {[obplt_pkg::OP_INSERT:obplt_pkg::OP_BEST]})
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= S_CNT;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_CNT:
                begin
                    if (div_done)
                    begin
                        best_idx_reg <= '0;
                        pend_reg     <= 1'b0;
                        if (op_reg == obplt_pkg::OP_BEST)
                        begin
                            state_reg <= S_BEST;
                        end
                        else
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= S_QDIV;
                        end
                    end
                end
                S_QDIV:
                begin
                    if (div_done)
                    begin
                        go_reg    <= 1'b1;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FRD;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FWT;
                end
                S_FWT:
                begin
                    state_reg <= S_SRD;
                end
                S_SRD:
                begin
                    state_reg <= (slot_i_reg == fill_reg) ? S_DEC : S_SCMP;
                end
                S_SCMP:
                begin
                    state_reg <= (id_q == id_reg) ? S_DEC : S_SRD;
                end
                S_DEC:
                begin
                    state_reg <= S_FIN;
                    if (op_reg == obplt_pkg::OP_INSERT && !hit_reg && fill_has_room)
                    begin
                        total_reg <= TW'(total_reg + TW'(1));
                    end
                    if (op_reg == obplt_pkg::OP_REMOVE && hit_reg)
                    begin
                        state_reg <= S_MRD;
                    end
                end
                S_MRD:
                begin
                    if (more_to_move)
                    begin
                        state_reg <= S_MWR;
                    end
                    else
                    begin
                        if (total_reg != '0)
                        begin
                            total_reg <= TW'(total_reg - TW'(1));
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_MWR:
                begin
                    state_reg <= S_MRD;
                end
                S_BEST:
                begin
                    if (best_idx_reg < count_reg)
                    begin
                        best_idx_reg <= CW'(best_idx_reg + CW'(1));
                        pend_reg     <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg         <= operation;
                id_reg         <= order_id;
                price_reg      <= price;
                res_status_reg <= (operation inside {obplt_pkg::OP_INSERT,
                                                     obplt_pkg::OP_REMOVE,
                                                     obplt_pkg::OP_LOOKUP}
                                   && price < cfg.lower_bound) ?
                                  obplt_pkg::ST_BELOW : obplt_pkg::ST_OK;
                res_found_reg  <= 1'b0;
                res_bv_reg     <= 1'b0;
                res_bp_reg     <= 32'd0;
                res_bid_reg    <= 32'd0;
            end
            S_CNT:
            begin
                if (div_done)
                begin
                    count_reg <= (div_quot >= 32'(LEVELS)) ? CW'(LEVELS) :
                                 CW'(div_quot + 32'd1);
                end
            end
            S_MOD:
            begin
                lvl_reg <= div_rem[LW-1:0];
            end
            S_FWT:
            begin
                fill_reg   <= fill_q;
                slot_i_reg <= '0;
                hit_reg    <= 1'b0;
            end
            S_SCMP:
            begin
                if (id_q == id_reg)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    slot_i_reg <= FW'(slot_i_reg + FW'(1));
                end
            end
            S_DEC:
            begin
                case (op_reg)
                    obplt_pkg::OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_status_reg <= obplt_pkg::ST_DUPLICATE;
                        end
                        else if (!fill_has_room)
                        begin
                            res_status_reg <= obplt_pkg::ST_FULL;
                        end
                    end
                    default:
                    begin
                        res_found_reg <= hit_reg;
                        if (!hit_reg)
                        begin
                            res_status_reg <= obplt_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_MWR:
            begin
                slot_i_reg <= FW'(slot_i_reg + FW'(1));
            end
            S_BEST:
            begin
                if (pend_reg && fill_q != '0 && best_better)
                begin
                    res_bv_reg  <= 1'b1;
                    res_bp_reg  <= price_q;
                    res_bid_reg <= id_q;
                end
                if (!(best_idx_reg < count_reg) && !pend_reg && !res_bv_reg)
                begin
                    res_status_reg <= obplt_pkg::ST_NOT_FOUND;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_status_reg <= res_status_reg;
                    out_found_reg  <= res_found_reg;
                    out_total_reg  <= 13'(total_reg);
                    out_bv_reg     <= res_bv_reg;
                    out_bp_reg     <= res_bp_reg;
                    out_bid_reg    <= res_bid_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found         = out_found_reg;
    assign total_orders  = out_total_reg;
    assign best_valid    = out_bv_reg;
    assign best_price    = out_bp_reg;
    assign best_order_id = out_bid_reg;

    `OBPLT_ASSERT_NXT(a_busy_after_accept, accept, !in_ready)
    `OBPLT_ASSERT_IMP(a_fill_bound, state_reg == S_DEC, {1'b0, fill_reg} <= (FW + 1)'(SLOTS))
    `OBPLT_ASSERT_IMP(a_count_range, state_reg == S_BEST,
                      count_reg != '0 && {1'b0, count_reg} <= (CW + 1)'(LEVELS))
    `OBPLT_ASSERT_IMP(a_total_bound, 1'b1, {1'b0, total_reg} <= (TW + 1)'(DEPTH))

endmodule

// ----- rtl/core/obplt_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Uses no package.
`timescale 1ns / 1ps
module obplt_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_reg, q_reg[31]};
    assign ge    = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 32'd0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[30:0], ge};
            r_reg <= ge ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ----- rtl/core/obplt_cfg.sv -----
// APB-style configuration registers for the price level table core.
// Depends on obplt_pkg for register codes and cfg_t.
`timescale 1ns / 1ps
module obplt_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output obplt_pkg::cfg_t  cfg
);

    obplt_pkg::cfg_t cfg_reg;
    logic            wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side        <= 1'b0;
            cfg_reg.tick        <= 16'd1;
            cfg_reg.lower_bound <= 32'd0;
            cfg_reg.upper_bound <= 32'd255;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                obplt_pkg::REG_SIDE:  cfg_reg.side        <= pwdata[0];
                obplt_pkg::REG_TICK:  cfg_reg.tick        <= pwdata[15:0];
                obplt_pkg::REG_LOWER: cfg_reg.lower_bound <= pwdata;
                obplt_pkg::REG_UPPER: cfg_reg.upper_bound <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            obplt_pkg::REG_SIDE:  prdata = {31'd0, cfg_reg.side};
            obplt_pkg::REG_TICK:  prdata = {16'd0, cfg_reg.tick};
            obplt_pkg::REG_LOWER: prdata = cfg_reg.lower_bound;
            obplt_pkg::REG_UPPER: prdata = cfg_reg.upper_bound;
            default:              prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule
